>>> sv/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Types, codes and helpers shared by the barrier and stepper sequencer.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int MAX_RESULTS = 3;
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [2:0] {
    REQ_TICK, REQ_MOVE, REQ_BARRIER, REQ_STOP,
    REQ_LEFT_ANGLE, REQ_RIGHT_ANGLE, REQ_LEFT_OFF, REQ_RIGHT_OFF
  } req_t;

  typedef enum logic [1:0] {PH_IDLE, PH_LEFT, PH_GAP, PH_RIGHT} phase_t;

  typedef enum logic [1:0] {POS_UNKNOWN, POS_OPEN, POS_CLOSED} pos_t;

  typedef enum logic [1:0] {ACT_COIL, ACT_ANGLE, ACT_OFF} action_t;

  typedef enum logic [2:0] {
    CFG_MOVE_MS, CFG_STAGGER_MS, CFG_STEP_MS,
    CFG_LEFT_OPEN, CFG_LEFT_CLOSED, CFG_RIGHT_OPEN, CFG_RIGHT_CLOSED
  } cfg_index_t;

  typedef struct packed {
    req_t        req;
    logic [15:0] step_count;
    logic        want_open;
    logic [7:0]  servo_degrees;
  } cmd_t;

  typedef struct packed {
    logic [15:0] move_ms;
    logic [15:0] stagger_ms;
    logic [15:0] step_ms;
    logic [7:0]  left_open;
    logic [7:0]  left_closed;
    logic [7:0]  right_open;
    logic [7:0]  right_closed;
  } cfg_t;

  typedef struct packed {
    action_t    action;
    logic       side;
    logic [7:0] angle;
    logic [3:0] coil;
  } result_t;

  typedef struct packed {
    pos_t        position;
    logic        busy;
    logic [14:0] steps_left;
  } status_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                count;
    status_t                   status;
  } batch_t;

  function automatic logic [7:0] sat_angle(input logic [7:0] a);
    return (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

  function automatic logic [3:0] coil_of(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd0:    c = 4'b0001;
      3'd1:    c = 4'b0011;
      3'd2:    c = 4'b0010;
      3'd3:    c = 4'b0110;
      3'd4:    c = 4'b0100;
      3'd5:    c = 4'b1100;
      3'd6:    c = 4'b1000;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

  function automatic result_t mk_res(input action_t act, input logic side,
                                     input logic [7:0] angle, input logic [3:0] coil);
    result_t r;
    r.action = act;
    r.side   = side;
    r.angle  = angle;
    r.coil   = coil;
    return r;
  endfunction

endpackage

>>> sv/barrier_and_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// barrier_and_stepper_sequencer
// Command-driven barrier servo sequencer and half-step stepper driver.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (req_type in s_tuser, operands in s_tdata);
// a tick command advances the millisecond clock, the barrier sequence and the
// stepper. Each command gives zero to three result transactions on the m_
// stream, action in m_tuser, m_tlast on the final result of one command.
// Registers are written through the cfg_ channel, which is always ready.
// A command taken from s_ lands in the input register, is evaluated
// combinationally and, if it has results, is loaded into the result register
// when it fires; its first result shows from there. A command with n results
// holds the single-ported result register, which drains them one a cycle
// whenever m_tready is high.
// Commands without results pass through at one per cycle.
// Reset clears time, sequence state and step count and loads the register
// defaults. When the receiver stalls, the result register holds, the input
// register fills, and s_tready drops until the results drain.
// ----------------------------------------------------------------------------
module barrier_and_stepper_sequencer import bss_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // step_count[15:0], want_open, servo_degrees[7:0],
                                 // zero pad
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // side, angle[7:0], coil[3:0], barrier_state[1:0],
                                 // barrier_busy, steps_left[14:0], zero pad
  output logic [1:0]  m_tuser,   // action[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg;
  cmd_t   cmd;
  logic   cmd_valid;
  logic   fire;
  logic   load;
  logic   can_load;
  batch_t batch;

  assign cfg_ready = 1'b1;
  assign fire      = cmd_valid && ((batch.count == 2'd0) || can_load);
  assign load      = fire && (batch.count != 2'd0);
  assign s_tready  = !cmd_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_ms      <= 16'd800;
      cfg.stagger_ms   <= 16'd300;
      cfg.step_ms      <= 16'd2;
      cfg.left_open    <= 8'd90;
      cfg.left_closed  <= 8'd0;
      cfg.right_open   <= 8'd90;
      cfg.right_closed <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MOVE_MS:      cfg.move_ms      <= cfg_data;
        CFG_STAGGER_MS:   cfg.stagger_ms   <= cfg_data;
        CFG_STEP_MS:      cfg.step_ms      <= cfg_data;
        CFG_LEFT_OPEN:    cfg.left_open    <= cfg_data[7:0];
        CFG_LEFT_CLOSED:  cfg.left_closed  <= cfg_data[7:0];
        CFG_RIGHT_OPEN:   cfg.right_open   <= cfg_data[7:0];
        CFG_RIGHT_CLOSED: cfg.right_closed <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      cmd.req           <= req_t'(s_tuser);
      cmd.step_count    <= s_tdata[15:0];
      cmd.want_open     <= s_tdata[16];
      cmd.servo_degrees <= s_tdata[24:17];
    end
  end

  bss_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cmd   (cmd),
    .fire  (fire),
    .batch (batch)
  );

  bss_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .batch_in (batch),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/bss_core.sv
// ----------------------------------------------------------------------------
// bss_core
// Sequencer state and single-pass command evaluation into a result batch.
// ----------------------------------------------------------------------------
module bss_core import bss_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  input  logic   fire,
  output batch_t batch
);

  logic [TIME_BITS-1:0] now_ms, now_ms_next;
  logic [TIME_BITS-1:0] barrier_mark, barrier_mark_next;
  logic [TIME_BITS-1:0] step_mark, step_mark_next;
  phase_t               phase, phase_next;
  pos_t                 position, position_next;
  logic                 goal_open, goal_open_next;
  logic                 step_forward, step_forward_next;
  logic [2:0]           phase_index, phase_index_next;
  logic [14:0]          steps_remaining, steps_remaining_next;

  logic [TIME_BITS-1:0] now_inc, bar_elapsed, step_elapsed, bar_limit;
  logic [2:0]           idx_adv;
  logic [15:0]          neg_count;
  logic [14:0]          mag;
  logic                 barrier_hit, step_hit;
  logic [1:0]           n;
  pos_t                 want_pos;

  assign now_inc      = now_ms + 1'b1;
  assign bar_elapsed  = now_inc - barrier_mark;
  assign step_elapsed = now_inc - step_mark;
  assign bar_limit    = (phase == PH_GAP) ? TIME_BITS'(cfg.stagger_ms)
                                          : TIME_BITS'(cfg.move_ms);
  assign idx_adv      = phase_index + (step_forward ? 3'd1 : 3'd7);
  assign neg_count    = 16'd0 - cmd.step_count;
  assign mag          = (cmd.step_count == 16'h8000) ? 15'h7FFF : neg_count[14:0];
  assign want_pos     = cmd.want_open ? POS_OPEN : POS_CLOSED;

  always_comb begin
    now_ms_next          = now_ms;
    barrier_mark_next    = barrier_mark;
    step_mark_next       = step_mark;
    phase_next           = phase;
    position_next        = position;
    goal_open_next       = goal_open;
    step_forward_next    = step_forward;
    phase_index_next     = phase_index;
    steps_remaining_next = steps_remaining;
    barrier_hit          = 1'b0;
    step_hit             = 1'b0;
    n                    = 2'd0;
    batch                = '0;

    unique case (cmd.req)
      REQ_TICK: begin
        now_ms_next = now_inc;
        barrier_hit = (phase != PH_IDLE) && (bar_elapsed >= bar_limit);
        if (barrier_hit) begin
          unique case (phase)
            PH_LEFT: begin
              batch.res[0]      = mk_res(ACT_OFF, SIDE_LEFT, 8'd0, 4'd0);
              barrier_mark_next = now_inc;
              phase_next        = PH_GAP;
            end
            PH_GAP: begin
              batch.res[0]      = mk_res(ACT_ANGLE, SIDE_RIGHT,
                sat_angle(goal_open ? cfg.right_open : cfg.right_closed), 4'd0);
              barrier_mark_next = now_inc;
              phase_next        = PH_RIGHT;
            end
            PH_RIGHT: begin
              batch.res[0]  = mk_res(ACT_OFF, SIDE_RIGHT, 8'd0, 4'd0);
              position_next = goal_open ? POS_OPEN : POS_CLOSED;
              phase_next    = PH_IDLE;
            end
            default: begin
              phase_next = phase;
            end
          endcase
          n = 2'd1;
        end
        step_hit = (phase_next == PH_IDLE) && (steps_remaining != 15'd0) &&
                   (step_elapsed >= TIME_BITS'(cfg.step_ms));
        if (step_hit) begin
          step_mark_next       = now_inc;
          phase_index_next     = idx_adv;
          steps_remaining_next = steps_remaining - 15'd1;
          batch.res[n]         = mk_res(ACT_COIL, SIDE_LEFT, 8'd0, coil_of(idx_adv));
          n                    = n + 2'd1;
          if (steps_remaining == 15'd1) begin
            batch.res[n] = mk_res(ACT_COIL, SIDE_LEFT, 8'd0, 4'd0);
            n            = n + 2'd1;
          end
        end
      end
      REQ_MOVE: begin
        if (cmd.step_count != 16'd0) begin
          step_forward_next    = ~cmd.step_count[15];
          steps_remaining_next = cmd.step_count[15] ? mag : cmd.step_count[14:0];
          step_mark_next       = now_ms;
        end
      end
      REQ_BARRIER: begin
        if ((phase == PH_IDLE) && (position != want_pos)) begin
          goal_open_next    = cmd.want_open;
          batch.res[0]      = mk_res(ACT_ANGLE, SIDE_LEFT,
            sat_angle(cmd.want_open ? cfg.left_open : cfg.left_closed), 4'd0);
          n                 = 2'd1;
          barrier_mark_next = now_ms;
          phase_next        = PH_LEFT;
        end
      end
      REQ_STOP: begin
        steps_remaining_next = 15'd0;
        batch.res[0]         = mk_res(ACT_COIL, SIDE_LEFT, 8'd0, 4'd0);
        batch.res[1]         = mk_res(ACT_OFF, SIDE_LEFT, 8'd0, 4'd0);
        batch.res[2]         = mk_res(ACT_OFF, SIDE_RIGHT, 8'd0, 4'd0);
        n                    = 2'd3;
        phase_next           = PH_IDLE;
      end
      REQ_LEFT_ANGLE: begin
        batch.res[0] = mk_res(ACT_ANGLE, SIDE_LEFT, sat_angle(cmd.servo_degrees), 4'd0);
        n            = 2'd1;
      end
      REQ_RIGHT_ANGLE: begin
        batch.res[0] = mk_res(ACT_ANGLE, SIDE_RIGHT, sat_angle(cmd.servo_degrees), 4'd0);
        n            = 2'd1;
      end
      REQ_LEFT_OFF: begin
        batch.res[0] = mk_res(ACT_OFF, SIDE_LEFT, 8'd0, 4'd0);
        n            = 2'd1;
      end
      default: begin
        batch.res[0] = mk_res(ACT_OFF, SIDE_RIGHT, 8'd0, 4'd0);
        n            = 2'd1;
      end
    endcase

    batch.count             = n;
    batch.status.position   = position_next;
    batch.status.busy       = (phase_next != PH_IDLE);
    batch.status.steps_left = steps_remaining_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms          <= '0;
      barrier_mark    <= '0;
      step_mark       <= '0;
      phase           <= PH_IDLE;
      position        <= POS_UNKNOWN;
      goal_open       <= 1'b0;
      step_forward    <= 1'b1;
      phase_index     <= 3'd0;
      steps_remaining <= 15'd0;
    end else if (fire) begin
      now_ms          <= now_ms_next;
      barrier_mark    <= barrier_mark_next;
      step_mark       <= step_mark_next;
      phase           <= phase_next;
      position        <= position_next;
      goal_open       <= goal_open_next;
      step_forward    <= step_forward_next;
      phase_index     <= phase_index_next;
      steps_remaining <= steps_remaining_next;
    end
  end

endmodule

>>> sv/bss_out.sv
// ----------------------------------------------------------------------------
// bss_out
// Result register: holds one batch, hands it out one transaction per ready cycle.
// ----------------------------------------------------------------------------
module bss_out import bss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  batch_t      batch_in,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // side, angle[7:0], coil[3:0], barrier_state[1:0],
                                 // barrier_busy, steps_left[14:0], zero pad
  output logic [1:0]  m_tuser,   // action[1:0]
  output logic        m_tlast
);

  batch_t     batch;
  logic [1:0] idx;
  logic       full;
  logic       is_last;
  result_t    cur;

  assign cur      = batch.res[idx];
  assign is_last  = (idx == batch.count - 2'd1);
  assign can_load = !full || (m_tready && is_last);
  assign m_tvalid = full;
  assign m_tlast  = is_last;
  assign m_tuser  = cur.action;
  assign m_tdata  = {1'b0, batch.status.steps_left, batch.status.busy,
                     batch.status.position, cur.coil, cur.angle, cur.side};

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 2'd0;
    end else if (full && m_tready) begin
      if (is_last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch <= batch_in;
    end
  end

endmodule
